// File: rtl/roext_pkg.sv
// Shared types, constants and the reciprocal table for the Romberg extrapolation table.
package roext_pkg;

    // Table geometry and number format.
    localparam int MAX_LEVELS = 20;
    localparam int FRAC_BITS  = 48;
    localparam int DATA_W     = 64;
    localparam int TOL_W      = 63;
    localparam int ROW_W      = 5;
    localparam int LEVELS_W   = 5;
    localparam int IDX_W      = $clog2(MAX_LEVELS);
    localparam int LEVEL_W    = $clog2(MAX_LEVELS + 1);

    // Reciprocals are unsigned Q0.62 values.
    localparam int RECIP_W     = 62;
    localparam int RECIP_SHIFT = 62;
    localparam int HALF_W      = DATA_W / 2;

    // Saturation limits of the signed data word.
    localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Register reset values.
    localparam logic [DATA_W-1:0]   REF_RESET    = DATA_W'(2) << FRAC_BITS;
    localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(1);
    localparam logic [LEVELS_W-1:0] LEVELS_RESET = LEVELS_W'(20);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS    = 2'd2;

    // Result status codes.
    localparam logic STATUS_ENTRY   = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    // Input and result payloads.
    typedef struct packed {
        logic signed [DATA_W-1:0] estimate;
        logic                     restart;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [ROW_W-1:0]         row;
        logic [ROW_W-1:0]         column;
        logic                     last;
        logic                     converged;
        logic                     status;
    } out_item_t;

    // Request and response of the shared multiply unit.
    typedef struct packed {
        logic                start;
        logic                neg;
        logic [DATA_W-1:0]   mag;
        logic [RECIP_W-1:0]  recip;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] value;
    } mul_rsp_t;

    // Per-cell control of the row chain.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    // round(2^62 / (4^j - 1)) is the sum of 2^(62 - 2jm) over m >= 1; the dropped
    // fraction is always below one half, so the rounded value is just these bits.
    typedef logic [MAX_LEVELS-1:0][RECIP_W-1:0] recip_table_t;

    function automatic recip_table_t build_recip_table();
        recip_table_t t;
        t = '0;
        for (int j = 1; j < MAX_LEVELS; j++) begin
            for (int m = 1; 2 * j * m <= RECIP_SHIFT; m++) begin
                t[j][RECIP_SHIFT - 2 * j * m] = 1'b1;
            end
        end
        return t;
    endfunction

    localparam recip_table_t RECIP_TABLE = build_recip_table();

endpackage

// File: rtl/roext_cell.sv
// One storage cell of the previous-row chain.
module roext_cell (
    input  logic                              aclk,
    input  roext_pkg::cell_ctl_t              ctl,
    input  logic [roext_pkg::DATA_W-1:0]      right_data,
    input  logic [roext_pkg::DATA_W-1:0]      new_data,
    output logic [roext_pkg::DATA_W-1:0]      q
);

    logic [roext_pkg::DATA_W-1:0] data_reg;

    // A load of a new entry wins over taking the right neighbor's value.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            data_reg <= new_data;
        end else if (ctl.shift) begin
            data_reg <= right_data;
        end
    end

    assign q = data_reg;

endmodule

// File: rtl/roext_mul.sv
// Multi-cycle signed scaling by a Q0.62 reciprocal, built on one 32 x 32 multiplier.
module roext_mul (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  roext_pkg::mul_req_t   req,
    output roext_pkg::mul_rsp_t   rsp
);

    localparam int ACC_W = roext_pkg::DATA_W + roext_pkg::RECIP_W + 1;
    localparam int Q_W   = ACC_W - roext_pkg::RECIP_SHIFT;

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_ACC, M_ROUND} phase_t;

    phase_t                           phase_reg;
    logic [1:0]                       cnt_reg;
    logic [1:0]                       sh_reg;
    logic [roext_pkg::DATA_W-1:0]     mag_reg;
    logic [roext_pkg::RECIP_W-1:0]    recip_reg;
    logic                             neg_reg;
    logic [ACC_W-1:0]                 acc_reg;
    logic [2*roext_pkg::HALF_W-1:0]   pp_reg;

    logic [roext_pkg::HALF_W-1:0]     a_op;
    logic [roext_pkg::HALF_W-1:0]     b_op;
    logic [2*roext_pkg::HALF_W-1:0]   product;
    logic [ACC_W-1:0]                 pp_ext;
    logic [ACC_W-1:0]                 pp_shifted;
    logic [ACC_W-1:0]                 acc_sum;
    logic [Q_W-1:0]                   q_full;
    logic [roext_pkg::DATA_W-1:0]     q_sat;

    // Operand halves: the count picks low or high half of each operand.
    always_comb begin
        a_op    = cnt_reg[1] ? mag_reg[roext_pkg::DATA_W-1:roext_pkg::HALF_W]
                             : mag_reg[roext_pkg::HALF_W-1:0];
        b_op    = cnt_reg[0]
                ? roext_pkg::HALF_W'(recip_reg[roext_pkg::RECIP_W-1:roext_pkg::HALF_W])
                : recip_reg[roext_pkg::HALF_W-1:0];
        product = a_op * b_op;
    end

    // Align the registered partial product by the weight of its halves.
    always_comb begin
        pp_ext = ACC_W'(pp_reg);
        case ({1'b0, sh_reg[0]} + {1'b0, sh_reg[1]})
            2'd0:    pp_shifted = pp_ext;
            2'd1:    pp_shifted = pp_ext << roext_pkg::HALF_W;
            default: pp_shifted = pp_ext << (2 * roext_pkg::HALF_W);
        endcase
        acc_sum = acc_reg + pp_shifted;
    end

    // Drop the reciprocal's fraction bits, clamp and restore the sign.
    always_comb begin
        q_full = acc_reg[ACC_W-1:roext_pkg::RECIP_SHIFT];
        if (q_full > Q_W'(roext_pkg::DATA_MAX)) begin
            q_sat = roext_pkg::DATA_MAX;
        end else begin
            q_sat = q_full[roext_pkg::DATA_W-1:0];
        end
        rsp.done  = (phase_reg == M_ROUND);
        rsp.value = neg_reg ? (roext_pkg::DATA_W'(0) - q_sat) : q_sat;
    end

    // Sequencer: four partial products, each registered and added to the accumulator in the next cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= M_IDLE;
            cnt_reg   <= '0;
        end else begin
            unique case (phase_reg)
                M_IDLE: begin
                    if (req.start) begin
                        mag_reg   <= req.mag;
                        recip_reg <= req.recip;
                        neg_reg   <= req.neg;
                        acc_reg   <= ACC_W'(1) << (roext_pkg::RECIP_SHIFT - 1);
                        cnt_reg   <= '0;
                        phase_reg <= M_MUL;
                    end
                end
                M_MUL: begin
                    pp_reg  <= product;
                    sh_reg  <= cnt_reg;
                    if (cnt_reg != 2'd0) begin
                        acc_reg <= acc_sum;
                    end
                    cnt_reg <= cnt_reg + 2'd1;
                    if (&cnt_reg) begin
                        phase_reg <= M_ACC;
                    end
                end
                M_ACC: begin
                    acc_reg   <= acc_sum;
                    phase_reg <= M_ROUND;
                end
                M_ROUND: begin
                    phase_reg <= M_IDLE;
                end
                default: begin
                    phase_reg <= M_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/romberg_extrapolation_table.sv
// Top level of the Romberg extrapolation table: sequencer, row chain and ports.
//
// Usage: each transaction on the s_ channel carries one trapezoid estimate
// for the next level k; restart high makes it R[0][0] of a new table. The
// block answers with the row R[k][0..k] on the m_ channel, one transaction
// per entry in column order, last set on the final one. The final entry of
// rows above zero carries converged when it lies within tolerance of the
// reference. After convergence or the last allowed row, an estimate without
// restart gets a single transaction with status and last set, all else zero.
// The block takes one item at a time: s_ready is high only while idle. Each
// column above zero passes through the shared 32 x 32 multiply unit (four
// partial products, a final add and rounding) and the sequencer's difference,
// start and add steps, and row k gets the convergence test when k > 0.
// The cfg_ channel is always ready; write it only while the block is idle.
// Reset leaves the table finished, so the first estimate must carry restart.
// When the receiver stalls, the output register holds its entry and the
// sequencer waits at the next entry; no data is lost.
module romberg_extrapolation_table (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  roext_pkg::in_item_t                   s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output roext_pkg::out_item_t                  m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [roext_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [roext_pkg::DATA_W-1:0]          cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_IGNORE, S_EMIT, S_DIFF, S_START, S_MUL, S_ADD, S_CONV
    } state_t;

    state_t                              state_reg;
    logic [roext_pkg::LEVEL_W-1:0]       level_reg;
    logic                                finished_reg;
    logic [roext_pkg::IDX_W-1:0]         k_reg;
    logic [roext_pkg::IDX_W-1:0]         col_reg;
    logic [roext_pkg::DATA_W-1:0]        cur_reg;
    logic [roext_pkg::DATA_W-1:0]        b_reg;
    logic [roext_pkg::DATA_W-1:0]        diff_reg;
    logic [roext_pkg::DATA_W-1:0]        prod_reg;
    logic                                conv_reg;
    logic                                out_valid_reg;
    roext_pkg::out_item_t                out_reg;

    logic [roext_pkg::DATA_W-1:0]        ref_reg;
    logic [roext_pkg::TOL_W-1:0]         tol_reg;
    logic [roext_pkg::LEVELS_W-1:0]      levels_reg;

    logic                                can_emit;
    logic                                load_out;
    logic                                row_end;
    logic                                pop;
    logic                                push;
    logic [roext_pkg::IDX_W-1:0]         wr_idx;
    logic                                is_ignored;
    logic [roext_pkg::LEVEL_W-1:0]       rows_allowed;
    logic [roext_pkg::LEVEL_W-1:0]       next_level;
    logic [roext_pkg::DATA_W:0]          diff_sum;
    logic [roext_pkg::DATA_W:0]          add_sum;
    logic [roext_pkg::DATA_W:0]          d_xr;
    logic [roext_pkg::DATA_W:0]          d_rx;
    logic [roext_pkg::DATA_W-1:0]        err_mag;
    logic                                near;

    roext_pkg::mul_req_t                 mul_req;
    roext_pkg::mul_rsp_t                 mul_rsp;
    roext_pkg::cell_ctl_t                cell_ctl [roext_pkg::MAX_LEVELS];
    logic [roext_pkg::DATA_W-1:0]        cell_q   [roext_pkg::MAX_LEVELS];

    // Clamp a 65-bit signed sum to the 64-bit signed range.
    function automatic logic [roext_pkg::DATA_W-1:0] sat_wide(
        input logic [roext_pkg::DATA_W:0] s
    );
        if (s[roext_pkg::DATA_W] != s[roext_pkg::DATA_W-1]) begin
            return s[roext_pkg::DATA_W] ? roext_pkg::DATA_MIN : roext_pkg::DATA_MAX;
        end
        return s[roext_pkg::DATA_W-1:0];
    endfunction

    // Handshake and chain control.
    always_comb begin
        can_emit   = !out_valid_reg || m_ready;
        load_out   = can_emit && (state_reg == S_EMIT || state_reg == S_IGNORE);
        row_end    = (col_reg == k_reg);
        push       = (state_reg == S_EMIT) && can_emit;
        pop        = push && (col_reg < k_reg);
        wr_idx     = pop ? (k_reg - roext_pkg::IDX_W'(1)) : k_reg;
        is_ignored = !s_data.restart
                   && (finished_reg || (int'(level_reg) >= roext_pkg::MAX_LEVELS));
        next_level = roext_pkg::LEVEL_W'(k_reg) + roext_pkg::LEVEL_W'(1);
    end

    // Effective number of rows per table.
    always_comb begin
        if (levels_reg == '0) begin
            rows_allowed = roext_pkg::LEVEL_W'(1);
        end else if (int'(levels_reg) > roext_pkg::MAX_LEVELS) begin
            rows_allowed = roext_pkg::LEVEL_W'(roext_pkg::MAX_LEVELS);
        end else begin
            rows_allowed = roext_pkg::LEVEL_W'(levels_reg);
        end
    end

    // Saturating difference and sum of the extrapolation step.
    always_comb begin
        diff_sum = {cur_reg[roext_pkg::DATA_W-1], cur_reg}
                 - {b_reg[roext_pkg::DATA_W-1], b_reg};
        add_sum  = {cur_reg[roext_pkg::DATA_W-1], cur_reg}
                 + {prod_reg[roext_pkg::DATA_W-1], prod_reg};
    end

    // Distance of the diagonal entry from the reference, compared exactly.
    always_comb begin
        d_xr    = {cur_reg[roext_pkg::DATA_W-1], cur_reg}
                - {ref_reg[roext_pkg::DATA_W-1], ref_reg};
        d_rx    = {ref_reg[roext_pkg::DATA_W-1], ref_reg}
                - {cur_reg[roext_pkg::DATA_W-1], cur_reg};
        err_mag = d_xr[roext_pkg::DATA_W] ? d_rx[roext_pkg::DATA_W-1:0]
                                          : d_xr[roext_pkg::DATA_W-1:0];
        near    = err_mag < {1'b0, tol_reg};
    end

    // Request to the multiply unit: magnitude, sign and reciprocal of this column.
    always_comb begin
        mul_req.start = (state_reg == S_START);
        mul_req.neg   = diff_reg[roext_pkg::DATA_W-1];
        mul_req.mag   = diff_reg[roext_pkg::DATA_W-1]
                      ? (roext_pkg::DATA_W'(0) - diff_reg) : diff_reg;
        mul_req.recip = roext_pkg::RECIP_TABLE[col_reg];
    end

    roext_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // Previous-row chain: the head cell is read, entries move toward it.
    for (genvar i = 0; i < roext_pkg::MAX_LEVELS; i++) begin : g_cell
        logic [roext_pkg::DATA_W-1:0] right_data;

        assign cell_ctl[i].shift = pop;
        assign cell_ctl[i].load  = push && (wr_idx == roext_pkg::IDX_W'(i));

        if (i == roext_pkg::MAX_LEVELS - 1) begin : g_tail
            assign right_data = '0;
        end else begin : g_body
            assign right_data = cell_q[i+1];
        end

        roext_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl[i]),
            .right_data (right_data),
            .new_data   (cur_reg),
            .q          (cell_q[i])
        );
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg    <= roext_pkg::REF_RESET;
            tol_reg    <= roext_pkg::TOL_RESET;
            levels_reg <= roext_pkg::LEVELS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                roext_pkg::CFG_REFERENCE: ref_reg    <= cfg_data;
                roext_pkg::CFG_TOLERANCE: tol_reg    <= cfg_data[roext_pkg::TOL_W-1:0];
                roext_pkg::CFG_LEVELS:    levels_reg <= cfg_data[roext_pkg::LEVELS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Row sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            finished_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (is_ignored) begin
                            state_reg <= S_IGNORE;
                        end else begin
                            cur_reg   <= s_data.estimate;
                            k_reg     <= s_data.restart ? '0
                                       : roext_pkg::IDX_W'(level_reg);
                            col_reg   <= '0;
                            conv_reg  <= 1'b0;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_IGNORE: begin
                    if (can_emit) begin
                        out_reg.value     <= '0;
                        out_reg.row       <= '0;
                        out_reg.column    <= '0;
                        out_reg.last      <= 1'b1;
                        out_reg.converged <= 1'b0;
                        out_reg.status    <= roext_pkg::STATUS_IGNORED;
                        finished_reg      <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (can_emit) begin
                        out_reg.value     <= cur_reg;
                        out_reg.row       <= roext_pkg::ROW_W'(k_reg);
                        out_reg.column    <= roext_pkg::ROW_W'(col_reg);
                        out_reg.last      <= row_end;
                        out_reg.converged <= row_end && conv_reg;
                        out_reg.status    <= roext_pkg::STATUS_ENTRY;
                        if (pop) begin
                            b_reg <= cell_q[0];
                        end
                        if (row_end) begin
                            level_reg    <= next_level;
                            finished_reg <= conv_reg || (next_level >= rows_allowed);
                            state_reg    <= S_IDLE;
                        end else begin
                            col_reg   <= col_reg + roext_pkg::IDX_W'(1);
                            state_reg <= S_DIFF;
                        end
                    end
                end
                S_DIFF: begin
                    diff_reg  <= sat_wide(diff_sum);
                    state_reg <= S_START;
                end
                S_START: begin
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    if (mul_rsp.done) begin
                        prod_reg  <= mul_rsp.value;
                        state_reg <= S_ADD;
                    end
                end
                S_ADD: begin
                    cur_reg   <= sat_wide(add_sum);
                    state_reg <= row_end ? S_CONV : S_EMIT;
                end
                S_CONV: begin
                    conv_reg  <= near;
                    state_reg <= S_EMIT;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // The level advances to one past the row whose last entry was just loaded for output.
    a_level_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && can_emit && row_end)
        |=> level_reg == roext_pkg::LEVEL_W'($past(k_reg)) + roext_pkg::LEVEL_W'(1))
        else $error("level did not advance after a finished row");

    // Converged is only ever reported on the final entry of a row.
    a_conv_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.converged) |-> m_data.last)
        else $error("converged set on an entry that is not last");

    // An entry's column never exceeds its row.
    a_col_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == roext_pkg::STATUS_ENTRY)
        |-> m_data.column <= m_data.row)
        else $error("column beyond row in emitted entry");

    // The multiply unit finishes only while the sequencer waits for it.
    a_mul_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> state_reg == S_MUL)
        else $error("multiply result arrived outside of the wait state");

endmodule
